>>> sv/plig_pkg.sv
// shared types, codes and decode tables for the polyline index generator
package plig_pkg;

  localparam int unsigned DEF_MAX_POINTS = 4096;
  localparam int unsigned DEF_CAP_SLICES = 12;
  localparam int unsigned DEF_INDEX_BITS = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned SLOT_W  = 17;
  localparam int unsigned VTX_W   = 32;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned SEG_W   = 12;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FROM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_TO    = 3'd4;

  localparam logic [COUNT_W-1:0] RANGE_TO_RESET = 13'd4096;

  // edge treatment codes
  localparam logic [1:0] MODE_BLUNT = 2'd0;
  localparam logic [1:0] MODE_CAP   = 2'd1;
  localparam logic [1:0] MODE_CYCLE = 2'd2;

  // request codes
  localparam logic [1:0] OP_SEGMENT = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [SEG_W-1:0] segment;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [VTX_W-1:0]  vertex_index;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]         edge_mode;
    logic [COUNT_W-1:0] point_count;
    logic [VTX_W-1:0]   base_offset;
    logic [COUNT_W-1:0] range_from;
    logic [COUNT_W-1:0] range_to;
  } cfg_t;

  typedef enum logic [2:0] {
    K_SEG,
    K_BLUNT_S,
    K_CAP_S,
    K_CLOSE,
    K_BLUNT_E,
    K_CAP_E
  } kind_t;

  // one piece of work handed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot0;
    logic [SLOT_W-1:0] slot1;
    logic [SLOT_W-1:0] slot2;
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
  } desc_t;

  // vertex pick for pieces built from groups of six: {use_b, add}
  // entry 0 in the low nibble of each row
  function automatic logic [3:0] six_pick(kind_t kind, logic [1:0] grp, logic [2:0] pos);
    logic [23:0] row;
    row = 24'h0;
    case (kind)
      K_SEG: begin
        case (grp)
          2'd0:    row = 24'h132120;
          2'd1:    row = 24'h02AA80;
          default: row = 24'h9B3931;
        endcase
      end
      K_CLOSE: begin
        case (grp)
          2'd0:    row = 24'h1BA1A0;
          2'd1:    row = 24'h0ACC80;
          default: row = 24'h9DB9B1;
        endcase
      end
      K_BLUNT_S: row = 24'h910890;
      K_BLUNT_E: row = 24'h89CCD8;
      default:   row = 24'h0;
    endcase
    return 4'(row >> {pos, 2'b00});
  endfunction

endpackage

>>> sv/plig_front.sv
// front end: takes request words, clamps the range and classifies them into work descriptors
module plig_front #(
  parameter int unsigned MAX_POINTS = plig_pkg::DEF_MAX_POINTS,
  parameter int unsigned CAP_SLICES = plig_pkg::DEF_CAP_SLICES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  plig_pkg::cfg_t    cfg,
  input  logic              in_push,
  input  plig_pkg::in_word_t in_word,
  output logic              in_full,
  output logic              q_push,
  output plig_pkg::desc_t   q_desc,
  input  logic              q_full
);
  import plig_pkg::*;

  localparam logic [16:0] MAXP = 17'(MAX_POINTS);
  localparam logic [SLOT_W-1:0] CAP_SPAN = SLOT_W'(3 * CAP_SLICES);
  localparam logic [VTX_W-1:0]  CAP_VTX  = VTX_W'(CAP_SLICES);

  logic     stage_v_r, stage_v_nxt;
  in_word_t stage_r, stage_nxt;

  logic [COUNT_W-1:0] pc, from, to, lim, seg13;
  logic [SLOT_W-1:0]  p17, s17, s6, p6, p12, p18;
  logic [VTX_W-1:0]   base, c2, c4, seg2;
  logic               active, cyc, start_ok, end_ok, hit, accept, done;
  desc_t              d;

  always_comb begin
    pc    = ({4'b0, cfg.point_count} > MAXP) ? COUNT_W'(MAXP) : cfg.point_count;
    from  = (cfg.range_from >= pc) ? '0 : cfg.range_from;
    to    = (cfg.range_to > pc) ? pc : cfg.range_to;
    lim   = ((pc - 13'd1) < to) ? (pc - 13'd1) : to;
    seg13 = {1'b0, stage_r.segment};

    active   = (pc >= 13'd2) && (from < to);
    cyc      = cfg.edge_mode == MODE_CYCLE;
    start_ok = from == '0;
    end_ok   = to == pc;

    p17 = SLOT_W'(pc);
    s17 = SLOT_W'(stage_r.segment);
    s6  = (s17 << 2) + (s17 << 1);
    p6  = (p17 << 2) + (p17 << 1);
    p12 = p6 << 1;
    p18 = p12 + p6;

    base = cfg.base_offset;
    c2   = base + (VTX_W'(pc) << 1);
    c4   = base + (VTX_W'(pc) << 2);
    seg2 = VTX_W'(stage_r.segment) << 1;

    d     = '0;
    d.kind = K_SEG;
    hit   = 1'b0;
    case (stage_r.op)
      OP_SEGMENT: begin
        hit     = active && (seg13 >= from) && (seg13 < lim);
        d.kind  = K_SEG;
        d.slot0 = s6;
        d.slot1 = s6 + p6 - (cyc ? 17'd0 : 17'd6);
        d.slot2 = s6 + p12 - (cyc ? 17'd0 : 17'd12);
        d.va    = base + seg2;
        d.vb    = c2 + seg2;
      end
      OP_START: begin
        d.slot0 = p18 - 17'd18;
        d.va    = c2;
        d.vb    = c4;
        if (cfg.edge_mode == MODE_BLUNT) begin
          hit    = active && start_ok;
          d.kind = K_BLUNT_S;
        end else if (cfg.edge_mode == MODE_CAP) begin
          hit    = active && start_ok;
          d.kind = K_CAP_S;
        end else if (cyc) begin
          hit     = active && (start_ok || end_ok);
          d.kind  = K_CLOSE;
          d.slot0 = p6 - 17'd6;
          d.slot1 = p12 - 17'd6;
          d.slot2 = p18 - 17'd6;
          d.va    = c2 - 32'd2;
          d.vb    = c4 - 32'd2;
        end
      end
      OP_END: begin
        if (cfg.edge_mode == MODE_BLUNT) begin
          hit     = active && end_ok;
          d.kind  = K_BLUNT_E;
          d.slot0 = p18 - 17'd12;
          d.vb    = c4 - 32'd2;
        end else if (cfg.edge_mode == MODE_CAP) begin
          hit     = active && end_ok;
          d.kind  = K_CAP_E;
          d.slot0 = p18 - 17'd18 + CAP_SPAN;
          d.va    = c4 - 32'd2;
          d.vb    = c4 + CAP_VTX;
        end
      end
      default: hit = 1'b0;
    endcase
  end

  // a word with nothing to emit is simply dropped
  assign done    = stage_v_r && (!hit || !q_full);
  assign q_push  = stage_v_r && hit && !q_full;
  assign q_desc  = d;
  assign in_full = stage_v_r && !done;
  assign accept  = in_push && !in_full;

  always_comb begin
    stage_v_nxt = stage_v_r;
    stage_nxt   = stage_r;
    if (accept) begin
      stage_v_nxt = 1'b1;
      stage_nxt   = in_word;
    end else if (done) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
    stage_r <= stage_nxt;
  end

endmodule

>>> sv/plig_fifo.sv
// short descriptor queue between front and back
module plig_fifo #(
  parameter int unsigned DEPTH = plig_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  plig_pkg::desc_t push_desc,
  output logic            full,
  input  logic            pop,
  output plig_pkg::desc_t pop_desc,
  output logic            valid
);
  import plig_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  desc_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = cnt_r == CNT_FULL;
  assign valid    = cnt_r != '0;
  assign pop_desc = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_nxt  = do_push ? ((wr_r == PTR_LAST) ? '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop ? ((rd_r == PTR_LAST) ? '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

endmodule

>>> sv/plig_back.sv
// back end: walks descriptors, one (slot, vertex) word per cycle unless held
module plig_back #(
  parameter int unsigned CAP_SLICES = plig_pkg::DEF_CAP_SLICES,
  parameter int unsigned INDEX_BITS = plig_pkg::DEF_INDEX_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  plig_pkg::desc_t    q_desc,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output plig_pkg::out_word_t out_word
);
  import plig_pkg::*;

  localparam int unsigned GRP_N = (CAP_SLICES > 3) ? CAP_SLICES : 3;
  localparam int unsigned GRP_W = $clog2(GRP_N);
  localparam int unsigned OFF_W = $clog2(CAP_SLICES + 6);
  localparam logic [GRP_W-1:0] CAP_LAST = GRP_W'(CAP_SLICES - 1);
  localparam logic [OFF_W-1:0] CAP_TOP  = OFF_W'(CAP_SLICES - 1);
  localparam logic [VTX_W-1:0] IDX_MASK = VTX_W'((64'd1 << INDEX_BITS) - 64'd1);

  desc_t             cur_r, cur_nxt;
  logic              busy_r, busy_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [GRP_W-1:0]  grp_r, grp_nxt, grp_top;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_v_r, out_v_nxt;

  logic             is_cap, pos_end, grp_end, last, step, load, pop_fire;
  logic             use_b;
  logic [OFF_W-1:0] add;
  logic [3:0]       pk;
  logic [VTX_W-1:0] vtx;

  always_comb begin
    is_cap  = (cur_r.kind == K_CAP_S) || (cur_r.kind == K_CAP_E);
    pos_end = is_cap ? (pos_r == 3'd2) : (pos_r == 3'd5);
    case (cur_r.kind)
      K_SEG, K_CLOSE:     grp_top = GRP_W'(2);
      K_CAP_S, K_CAP_E:   grp_top = CAP_LAST;
      default:            grp_top = '0;
    endcase
    grp_end = grp_r == grp_top;
    last    = pos_end && grp_end;

    pk    = six_pick(cur_r.kind, grp_r[1:0], pos_r);
    use_b = pk[3];
    add   = OFF_W'(pk[2:0]);
    // fan triangles: first and last close onto the rim, the rest walk the arc
    if (cur_r.kind == K_CAP_S) begin
      if (grp_r == '0) begin
        use_b = pos_r != 3'd2;
        add   = (pos_r == 3'd1) ? OFF_W'(1) : '0;
      end else if (grp_r == CAP_LAST) begin
        use_b = pos_r != 3'd1;
        add   = (pos_r == 3'd0) ? '0 : ((pos_r == 3'd1) ? OFF_W'(1) : CAP_TOP);
      end else begin
        use_b = 1'b1;
        add   = (pos_r == 3'd0) ? OFF_W'(grp_r) :
                ((pos_r == 3'd1) ? '0 : OFF_W'(grp_r) + OFF_W'(1));
      end
    end else if (cur_r.kind == K_CAP_E) begin
      if (grp_r == '0) begin
        use_b = pos_r != 3'd2;
        add   = (pos_r == 3'd0) ? '0 : OFF_W'(1);
      end else if (grp_r == CAP_LAST) begin
        use_b = pos_r != 3'd1;
        add   = (pos_r == 3'd2) ? CAP_TOP : '0;
      end else begin
        use_b = 1'b1;
        add   = (pos_r == 3'd0) ? '0 :
                ((pos_r == 3'd1) ? OFF_W'(grp_r) + OFF_W'(1) : OFF_W'(grp_r));
      end
    end
    vtx = ((use_b ? cur_r.vb : cur_r.va) + VTX_W'(add)) & IDX_MASK;
  end

  assign pop_fire  = out_pop && out_v_r;
  assign step      = busy_r && (!out_v_r || pop_fire);
  assign load      = q_valid && (!busy_r || (step && last));
  assign q_pop     = load;
  assign out_empty = !out_v_r;
  assign out_word  = out_r;

  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    pos_nxt   = pos_r;
    grp_nxt   = grp_r;
    slot_nxt  = slot_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (pop_fire) begin
      out_v_nxt = 1'b0;
    end
    if (step) begin
      out_nxt.slot         = slot_r;
      out_nxt.vertex_index = vtx;
      out_nxt.last         = last;
      out_v_nxt            = 1'b1;
      if (pos_end) begin
        pos_nxt = '0;
        grp_nxt = grp_r + 1'b1;
        if (is_cap) begin
          slot_nxt = slot_r + 1'b1;
        end else begin
          slot_nxt = (grp_r == '0) ? cur_r.slot1 : cur_r.slot2;
        end
      end else begin
        pos_nxt  = pos_r + 1'b1;
        slot_nxt = slot_r + 1'b1;
      end
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      cur_nxt  = q_desc;
      busy_nxt = 1'b1;
      pos_nxt  = '0;
      grp_nxt  = '0;
      slot_nxt = q_desc.slot0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      out_v_r <= out_v_nxt;
    end
    cur_r  <= cur_nxt;
    pos_r  <= pos_nxt;
    grp_r  <= grp_nxt;
    slot_r <= slot_nxt;
    out_r  <= out_nxt;
  end

endmodule

>>> sv/polyline_index_generate.sv
// top level of the polyline index generator: config registers, front, queue and back
// path: a request's first word passes the front stage, queue, back-end and output registers
// throughput: one word per cycle while out_pop keeps up, set by the back-end sequencer; a
//   segment or closing piece gives 18 words, a blunt edge 6 and a round cap 3*CAP_SLICES;
//   requests with no output are dropped in the front stage without reaching the back end
// reset: synchronous, active low; clears the front stage, queue and back end, and loads
//   the config registers with their reset values (range_to reads 4096, the rest 0)
module polyline_index_generate #(
  parameter int unsigned MAX_POINTS = plig_pkg::DEF_MAX_POINTS,
  parameter int unsigned CAP_SLICES = plig_pkg::DEF_CAP_SLICES,
  parameter int unsigned INDEX_BITS = plig_pkg::DEF_INDEX_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request words
  input  logic                                in_push,
  input  plig_pkg::in_word_t                  in_word,
  output logic                                in_full,
  // result words
  output logic                                out_empty,
  input  logic                                out_pop,
  output plig_pkg::out_word_t                 out_word,
  // config writes
  input  logic                                cfg_we,
  input  logic [plig_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [plig_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import plig_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_full, q_pop, q_valid;
  desc_t q_in, q_out;

  // config register file, write only; indexes past the list are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_EDGE_MODE:   cfg_nxt.edge_mode   = cfg_wdata[1:0];
        CFG_POINT_COUNT: cfg_nxt.point_count = cfg_wdata[COUNT_W-1:0];
        CFG_BASE_OFFSET: cfg_nxt.base_offset = cfg_wdata[VTX_W-1:0];
        CFG_RANGE_FROM:  cfg_nxt.range_from  = cfg_wdata[COUNT_W-1:0];
        CFG_RANGE_TO:    cfg_nxt.range_to    = cfg_wdata[COUNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.edge_mode   <= MODE_BLUNT;
      cfg_r.point_count <= '0;
      cfg_r.base_offset <= '0;
      cfg_r.range_from  <= '0;
      cfg_r.range_to    <= RANGE_TO_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: one register stage, clamps the range and turns each word with output into a descriptor
  plig_front #(
    .MAX_POINTS (MAX_POINTS),
    .CAP_SLICES (CAP_SLICES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .q_push  (q_push),
    .q_desc  (q_in),
    .q_full  (q_full)
  );

  // descriptor queue lets the front keep taking words while the back is busy
  plig_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (q_out),
    .valid     (q_valid)
  );

  // back: walks each descriptor, output register parts it from the result side
  plig_back #(
    .CAP_SLICES (CAP_SLICES),
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_desc    (q_out),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
